// ----- sv/relative_motion_to_scroll_macros.svh -----
// assertion macros for the relative_motion_to_scroll block
// expects clk_i and rst_ni in the scope of the including module
`ifndef RELATIVE_MOTION_TO_SCROLL_MACROS_SVH
`define RELATIVE_MOTION_TO_SCROLL_MACROS_SVH

// same-cycle implication
`define RMTS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rmts_pkg.sv -----
// shared types, codes and widths for relative_motion_to_scroll
// no dependencies
`default_nettype none

package rmts_pkg;

  localparam int unsigned TYPE_W  = 5;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned RES_W   = DIV_W + 1;
  localparam int unsigned SUM_W   = VALUE_W + 1;
  localparam int unsigned CNT_W   = $clog2(SUM_W);
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
  localparam logic [TYPE_W-1:0] TYPE_REL  = 5'd2;

  localparam logic [CODE_W-1:0] CODE_X      = 10'd0;
  localparam logic [CODE_W-1:0] CODE_Y      = 10'd1;
  localparam logic [CODE_W-1:0] CODE_HWHEEL = 10'd6;
  localparam logic [CODE_W-1:0] CODE_WHEEL  = 10'd8;

  localparam logic [1:0] REG_TRIGGER = 2'd0;
  localparam logic [1:0] REG_X_DIV   = 2'd1;
  localparam logic [1:0] REG_Y_DIV   = 2'd2;

  localparam logic [VALUE_W-1:0] SAT_POS   = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] SAT_NEG   = 32'h8000_0000;
  localparam logic [SUM_W-1:0]   POS_LIMIT = 33'h0_7fff_ffff;
  localparam logic [SUM_W-1:0]   NEG_LIMIT = 33'h0_8000_0000;

  typedef struct packed {
    logic [TYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]         event_code;
    logic signed [VALUE_W-1:0] event_value;
  } rmts_in_t;

  typedef struct packed {
    logic [TYPE_W-1:0]         out_type;
    logic [CODE_W-1:0]         out_code;
    logic signed [VALUE_W-1:0] out_value;
  } rmts_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] trigger_code;
    logic [DIV_W-1:0]  x_divisor;
    logic [DIV_W-1:0]  y_divisor;
  } rmts_cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] quo_mag;
    logic [DIV_W-1:0] rem_mag;
    logic             neg;
  } rmts_div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } rmts_state_e;

endpackage

`default_nettype wire

// ----- sv/rmts_regs.sv -----
// configuration registers behind the apb-style port
// depends on rmts_pkg
`default_nettype none

module rmts_regs
  import rmts_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output rmts_cfg_t               cfg_o
);

  rmts_cfg_t  cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TRIGGER: cfg_d.trigger_code = pwdata[CODE_W-1:0];
        REG_X_DIV:   cfg_d.x_divisor    = pwdata[DIV_W-1:0];
        REG_Y_DIV:   cfg_d.y_divisor    = pwdata[DIV_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TRIGGER: prdata = PDATA_W'(cfg_q.trigger_code);
      REG_X_DIV:   prdata = PDATA_W'(cfg_q.x_divisor);
      REG_Y_DIV:   prdata = PDATA_W'(cfg_q.y_divisor);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_code <= '0;
      cfg_q.x_divisor    <= DIV_W'(1);
      cfg_q.y_divisor    <= DIV_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rmts_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle, sign-magnitude
// depends on rmts_pkg
`default_nettype none

module rmts_div
  import rmts_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0]        divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output rmts_div_res_t                res_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             last;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign last    = (cnt_q == CNT_W'(SUM_W - 1));
  assign busy_o  = busy_q;
  assign done_o  = busy_q && last;
  assign res_o   = '{quo_mag: quo_q, rem_mag: rem_q, neg: neg_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // trial subtract, keep when no borrow
      rem_d = diff[DIV_W+1] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ~diff[DIV_W+1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

endmodule

`default_nettype wire

// ----- sv/relative_motion_to_scroll.sv -----
// relative_motion_to_scroll top level: event filter, sequencer, output register
// depends on rmts_pkg, rmts_regs, rmts_div and relative_motion_to_scroll_macros.svh
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------
//   input    | in_valid_i / in_ready_o | in_data_i  (rmts_in_t)
//   output   | out_valid_o/ out_ready_i| out_data_o (rmts_out_t)
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata
//
// forwarded events go via item_q and res_q (EVAL, EMIT) to the output register once it is free
// scroll-mode x/y motion goes EVAL, 33-step divider, FIN, EMIT; a zero quotient emits nothing
// one event in flight; in_ready_o is high only while the sequencer is idle
// a result may wait in the output register while the next event is taken
// reset clears mode, sync-drop flag and both residues; no clearing pass
`default_nettype none

module relative_motion_to_scroll
  import rmts_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rmts_in_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rmts_out_t               out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

`include "relative_motion_to_scroll_macros.svh"

  rmts_state_e   state_q, state_d;
  rmts_cfg_t     cfg;
  rmts_in_t      item_q;
  rmts_out_t     res_q, out_q;
  logic          out_valid_q;
  logic          scroll_q, drop_q;
  logic signed [RES_W-1:0] x_res_q, y_res_q;

  logic          is_drop, is_trig, is_axis, is_y;
  logic signed [RES_W-1:0] res_sel;
  logic signed [SUM_W-1:0] sum;
  logic [DIV_W-1:0] dvs_sel;
  logic          div_start, div_busy, div_done;
  rmts_div_res_t div_res;
  logic signed [RES_W-1:0] new_res;
  logic [VALUE_W-1:0] quo_val;
  logic          quo_zero;
  logic          slot_free, out_load;

  rmts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rmts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (dvs_sel),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // event classification
  assign is_drop = (item_q.event_type == TYPE_SYNC) && drop_q;
  assign is_trig = (item_q.event_type == TYPE_KEY) &&
                   (item_q.event_code == cfg.trigger_code);
  assign is_y    = (item_q.event_code == CODE_Y);
  assign is_axis = scroll_q && (item_q.event_type == TYPE_REL) &&
                   ((item_q.event_code == CODE_X) || is_y);

  assign res_sel = is_y ? y_res_q : x_res_q;
  assign sum     = SUM_W'(res_sel) + SUM_W'(item_q.event_value);
  always_comb begin
    dvs_sel = is_y ? cfg.y_divisor : cfg.x_divisor;
    if (dvs_sel == '0) begin
      dvs_sel = DIV_W'(1);
    end
  end

  // sign fix and saturation
  assign new_res  = div_res.neg ? -RES_W'({1'b0, div_res.rem_mag})
                                : RES_W'({1'b0, div_res.rem_mag});
  assign quo_zero = (div_res.quo_mag == '0);
  always_comb begin
    if (!div_res.neg) begin
      quo_val = (div_res.quo_mag > POS_LIMIT) ? SAT_POS : div_res.quo_mag[VALUE_W-1:0];
    end else begin
      quo_val = (div_res.quo_mag > NEG_LIMIT) ? SAT_NEG
                                              : (~div_res.quo_mag[VALUE_W-1:0] + VALUE_W'(1));
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (is_drop || is_trig) begin
          state_d = ST_IDLE;
        end else if (is_axis) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = quo_zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EVAL: div_start  = !is_drop && !is_trig && is_axis;
      ST_EMIT: out_load   = slot_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scroll_q    <= 1'b0;
      drop_q      <= 1'b0;
      x_res_q     <= '0;
      y_res_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EVAL) begin
        drop_q <= is_trig && !is_drop;
        if (is_trig && !is_drop) begin
          scroll_q <= (item_q.event_value != '0);
        end
      end
      if (state_q == ST_FIN) begin
        drop_q <= quo_zero;
        if (is_y) begin
          y_res_q <= new_res;
        end else begin
          x_res_q <= new_res;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_EVAL) begin
      res_q <= '{out_type: item_q.event_type, out_code: item_q.event_code,
                 out_value: item_q.event_value};
    end else if (state_q == ST_FIN) begin
      res_q <= '{out_type: TYPE_REL, out_code: (is_y ? CODE_WHEEL : CODE_HWHEEL),
                 out_value: quo_val};
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RMTS_ASSERT_IMPL(a_load_slot_free, out_load, !out_valid_q || out_ready_i, "output overwritten")
  `RMTS_ASSERT_IMPL(a_start_idle_div, div_start, !div_busy, "divider restarted while busy")
  `RMTS_ASSERT_IMPL(a_ready_div_idle, in_ready_o, !div_busy, "input taken while divider busy")
  `RMTS_ASSERT_NEXT(a_done_leaves_div, div_done, state_q == ST_FIN && !div_busy, "done lost")

endmodule

`default_nettype wire
